// ===== rtl/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants of the I2C byte master: command codes,
// sequencer phases, payload structs and register reset values.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    localparam int DELAY_W   = 16;
    localparam int POLL_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int BITCNT_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [DELAY_W-1:0] HALF_PERIOD_RST = 16'd100;
    localparam logic [DELAY_W-1:0] START_DELAY_RST = 16'd100;
    localparam logic [POLL_W-1:0]  ACK_LIMIT_RST   = 8'd250;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE  = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_WACK  = 3'd4,
        CMD_READ  = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_PERIOD = 2'd0,
        CFG_START_DELAY = 2'd1,
        CFG_ACK_LIMIT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [15:0] {
        PH_IDLE    = 16'b0000_0000_0000_0001,
        PH_ST_A    = 16'b0000_0000_0000_0010,
        PH_ST_B    = 16'b0000_0000_0000_0100,
        PH_ST_C1   = 16'b0000_0000_0000_1000,
        PH_ST_C2   = 16'b0000_0000_0001_0000,
        PH_SP_A    = 16'b0000_0000_0010_0000,
        PH_SP_B    = 16'b0000_0000_0100_0000,
        PH_WA_A    = 16'b0000_0000_1000_0000,
        PH_WA_B    = 16'b0000_0001_0000_0000,
        PH_WA_POLL = 16'b0000_0010_0000_0000,
        PH_WB_LO   = 16'b0000_0100_0000_0000,
        PH_WB_HI   = 16'b0000_1000_0000_0000,
        PH_RB_LO   = 16'b0001_0000_0000_0000,
        PH_RB_HI   = 16'b0010_0000_0000_0000,
        PH_RA_LO   = 16'b0100_0000_0000_0000,
        PH_RA_HI   = 16'b1000_0000_0000_0000
    } t_phase;

    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] write_data;
        logic              send_ack;
        logic              sda_in;
    } t_in;

    typedef struct packed {
        logic              scl_drive;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic              ack_error;
    } t_out;

    // A zero delay register counts as one tick.
    function automatic logic [DELAY_W-1:0] ticks_of(input logic [DELAY_W-1:0] v);
        return (v == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

// ===== rtl/i2c_byte_master_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_byte_master_unit
// Bit-level I2C master sequencer: start, stop, byte write, acknowledge wait
// and byte read with ACK/NACK, timed in input ticks.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------
//  input    | in        | i_valid / o_stall          | i_in  (t_in : one tick)
//  output   | out       | o_valid / i_stall          | o_out (t_out: line drives)
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One tick item is taken per clock while o_stall is low; its result
//  appears in the output register on the next cycle.
//  The only loop is the sequencer state itself, at most one phase step per tick.
//  Reset (synchronous, active low) puts the sequencer in idle with both
//  lines released and the registers at their default timings.
//  o_stall rises only while a result waits and the sink stalls; then the
//  tick is held off and no state advances.
// ----------------------------------------------------------------------------
module i2c_byte_master_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // tick input
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  i2cbm_pkg::t_in                         i_in,
    // result output
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output i2cbm_pkg::t_out                        o_out,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [i2cbm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [i2cbm_pkg::CFG_DAT_W-1:0]        i_cfg_data
);

    // Configuration registers
    logic [i2cbm_pkg::DELAY_W-1:0] r_half_period;
    logic [i2cbm_pkg::DELAY_W-1:0] r_start_delay;
    logic [i2cbm_pkg::POLL_W-1:0]  r_ack_limit;

    // Sequencer state
    i2cbm_pkg::t_phase              r_phase,       n_phase;
    logic [i2cbm_pkg::BITCNT_W-1:0] r_bit_count,   n_bit_count;
    logic [i2cbm_pkg::BYTE_W-1:0]   r_shift,       n_shift;
    logic [i2cbm_pkg::DELAY_W-1:0]  r_delay,       n_delay;
    logic [i2cbm_pkg::POLL_W-1:0]   r_poll,        n_poll;
    logic                           r_scl,         n_scl;
    logic                           r_sda,         n_sda;
    logic                           r_ack_flag,    n_ack_flag;
    logic                           r_ack_choice,  n_ack_choice;
    logic [i2cbm_pkg::BYTE_W-1:0]   r_held_read,   n_held_read;

    // Output register
    logic                           r_out_valid;
    i2cbm_pkg::t_out                r_out;

    logic                           w_accept;
    logic                           w_done;
    logic [i2cbm_pkg::DELAY_W-1:0]  w_dec;
    logic [i2cbm_pkg::BITCNT_W-1:0] w_bit_inc;

    // Hold the tick off only while a finished result is stuck at the sink.
    assign o_stall     = r_out_valid && i_stall;
    assign w_accept    = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration: writes land at any time; unknown indexes are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cbm_pkg::HALF_PERIOD_RST;
            r_start_delay <= i2cbm_pkg::START_DELAY_RST;
            r_ack_limit   <= i2cbm_pkg::ACK_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i2cbm_pkg::t_cfg_idx'(i_cfg_index))
                i2cbm_pkg::CFG_HALF_PERIOD: begin
                    r_half_period <= i_cfg_data;
                end
                i2cbm_pkg::CFG_START_DELAY: begin
                    r_start_delay <= i_cfg_data;
                end
                i2cbm_pkg::CFG_ACK_LIMIT: begin
                    r_ack_limit <= i_cfg_data[i2cbm_pkg::POLL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // One tick of the sequencer. Each timed phase is a segment that holds the
    // line levels for a counted number of ticks; the segment end picks
    // the next phase or finishes the command.
    // ------------------------------------------------------------------
    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_poll       = r_poll;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_flag   = r_ack_flag;
        n_ack_choice = r_ack_choice;
        n_held_read  = r_held_read;
        w_done       = 1'b0;
        w_dec        = (r_delay != '0) ? (r_delay - 1'b1) : r_delay;
        w_bit_inc    = r_bit_count + 1'b1;

        if (r_phase == i2cbm_pkg::PH_IDLE) begin
            // Decode a new command; codes six and seven fall to default.
            unique case (i_in.cmd)
                i2cbm_pkg::CMD_START: begin
                    n_phase = i2cbm_pkg::PH_ST_A;
                    n_delay = i2cbm_pkg::ticks_of(r_start_delay);
                end
                i2cbm_pkg::CMD_STOP: begin
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                    n_phase = i2cbm_pkg::PH_SP_A;
                    n_delay = i2cbm_pkg::ticks_of(r_half_period);
                end
                i2cbm_pkg::CMD_WRITE: begin
                    n_scl       = 1'b0;
                    n_shift     = i_in.write_data;
                    n_bit_count = '0;
                    n_phase     = i2cbm_pkg::PH_WB_LO;
                    n_delay     = i2cbm_pkg::ticks_of(r_half_period);
                end
                i2cbm_pkg::CMD_WACK: begin
                    n_sda   = 1'b1;
                    n_phase = i2cbm_pkg::PH_WA_A;
                    n_delay = i2cbm_pkg::ticks_of(r_half_period);
                end
                i2cbm_pkg::CMD_READ: begin
                    n_scl        = 1'b0;
                    n_sda        = 1'b1;
                    n_shift      = '0;
                    n_bit_count  = '0;
                    n_ack_choice = i_in.send_ack;
                    n_phase      = i2cbm_pkg::PH_RB_LO;
                    n_delay      = i2cbm_pkg::ticks_of(r_half_period);
                end
                default: begin
                end
            endcase
        end else if (r_phase == i2cbm_pkg::PH_WA_POLL) begin
            // Poll SDA once per tick; low is an ACK.
            if (!i_in.sda_in) begin
                n_ack_flag = 1'b0;
                n_scl      = 1'b0;
                w_done     = 1'b1;
            end else if (r_poll >= r_ack_limit) begin
                n_ack_flag = 1'b1;
                w_done     = 1'b1;
            end else begin
                n_poll = r_poll + 1'b1;
            end
        end else begin
            // Drive data during the low half of write and ack bits.
            if (r_phase == i2cbm_pkg::PH_WB_LO) begin
                n_sda = r_shift[i2cbm_pkg::BYTE_W-1];
            end else if (r_phase == i2cbm_pkg::PH_RA_LO) begin
                n_sda = !r_ack_choice;
            end
            n_delay = w_dec;

            if (w_dec == '0) begin
                unique case (r_phase)
                    i2cbm_pkg::PH_ST_A: begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_phase = i2cbm_pkg::PH_ST_B;
                        n_delay = i2cbm_pkg::ticks_of(r_start_delay);
                    end
                    i2cbm_pkg::PH_ST_B: begin
                        n_sda   = 1'b0;
                        n_phase = i2cbm_pkg::PH_ST_C1;
                        n_delay = i2cbm_pkg::ticks_of(r_start_delay);
                    end
                    i2cbm_pkg::PH_ST_C1: begin
                        n_phase = i2cbm_pkg::PH_ST_C2;
                        n_delay = i2cbm_pkg::ticks_of(r_start_delay);
                    end
                    i2cbm_pkg::PH_ST_C2: begin
                        n_scl  = 1'b0;
                        w_done = 1'b1;
                    end
                    i2cbm_pkg::PH_SP_A: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_phase = i2cbm_pkg::PH_SP_B;
                        n_delay = i2cbm_pkg::ticks_of(r_half_period);
                    end
                    i2cbm_pkg::PH_SP_B: begin
                        w_done = 1'b1;
                    end
                    i2cbm_pkg::PH_WA_A: begin
                        n_scl   = 1'b1;
                        n_phase = i2cbm_pkg::PH_WA_B;
                        n_delay = i2cbm_pkg::ticks_of(r_half_period);
                    end
                    i2cbm_pkg::PH_WA_B: begin
                        n_phase = i2cbm_pkg::PH_WA_POLL;
                        n_poll  = '0;
                    end
                    i2cbm_pkg::PH_WB_LO: begin
                        n_scl   = 1'b1;
                        n_phase = i2cbm_pkg::PH_WB_HI;
                        n_delay = i2cbm_pkg::ticks_of(r_half_period);
                    end
                    i2cbm_pkg::PH_WB_HI: begin
                        n_shift     = {r_shift[i2cbm_pkg::BYTE_W-2:0], 1'b0};
                        n_bit_count = w_bit_inc;
                        n_scl       = 1'b0;
                        if (w_bit_inc >= i2cbm_pkg::BITS_PER_BYTE) begin
                            w_done = 1'b1;
                        end else begin
                            n_phase = i2cbm_pkg::PH_WB_LO;
                            n_delay = i2cbm_pkg::ticks_of(r_half_period);
                        end
                    end
                    i2cbm_pkg::PH_RB_LO: begin
                        n_scl   = 1'b1;
                        n_phase = i2cbm_pkg::PH_RB_HI;
                        n_delay = i2cbm_pkg::ticks_of(r_half_period);
                    end
                    i2cbm_pkg::PH_RB_HI: begin
                        // Sample SDA on the last high tick.
                        n_shift     = {r_shift[i2cbm_pkg::BYTE_W-2:0], i_in.sda_in};
                        n_bit_count = w_bit_inc;
                        n_scl       = 1'b0;
                        n_phase     = (w_bit_inc >= i2cbm_pkg::BITS_PER_BYTE)
                                      ? i2cbm_pkg::PH_RA_LO : i2cbm_pkg::PH_RB_LO;
                        n_delay     = i2cbm_pkg::ticks_of(r_half_period);
                    end
                    i2cbm_pkg::PH_RA_LO: begin
                        n_scl   = 1'b1;
                        n_phase = i2cbm_pkg::PH_RA_HI;
                        n_delay = i2cbm_pkg::ticks_of(r_half_period);
                    end
                    i2cbm_pkg::PH_RA_HI: begin
                        n_scl       = 1'b0;
                        n_held_read = r_shift;
                        w_done      = 1'b1;
                    end
                    default: begin
                        w_done = 1'b1;
                    end
                endcase
            end
        end

        if (w_done) begin
            n_phase = i2cbm_pkg::PH_IDLE;
        end
    end

    // ------------------------------------------------------------------
    // State and result registers advance only on an accepted tick.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cbm_pkg::PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_delay      <= '0;
            r_poll       <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack_flag   <= 1'b0;
            r_ack_choice <= 1'b0;
            r_held_read  <= '0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_poll       <= n_poll;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_ack_flag   <= n_ack_flag;
            r_ack_choice <= n_ack_choice;
            r_held_read  <= n_held_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.scl_drive <= n_scl;
            r_out.sda_drive <= n_sda;
            r_out.busy_res  <= (n_phase != i2cbm_pkg::PH_IDLE);
            r_out.done_res  <= w_done;
            r_out.read_byte <= n_held_read;
            r_out.ack_error <= n_ack_flag;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done result still reports busy");

    a_ack_err_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ack_flag) |-> $past(r_phase == i2cbm_pkg::PH_WA_POLL))
        else $error("ack error set outside acknowledge polling");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= i2cbm_pkg::BITS_PER_BYTE)
        else $error("bit counter beyond one byte");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted tick produced no result");

    a_freeze_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_phase) && $stable(r_delay))
        else $error("sequencer advanced while stalled");

endmodule

// ===== tb/i2c_byte_master_unit_test.sv =====
// ----------------------------------------------------------------------------
// i2c_byte_master_unit_test
// Self-checking bench for the I2C byte master. Ticks enter with random gaps
// and the result side stalls at random. A model of the bit sequencer inside
// the bench predicts the line drives and status for every tick, and a checker
// compares each result with the oldest prediction. Directed command sequences
// come first, then random bus transfers under several timing settings and
// result-side hold-offs, then the highest acknowledge limit.
// ----------------------------------------------------------------------------
module i2c_byte_master_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbm_pkg::*;

    // Command codes the block must ignore
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    // Register index past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Register values after reset
    localparam logic [15:0] DFLT_HALF    = 16'd100;
    localparam logic [15:0] DFLT_START   = 16'd100;
    localparam logic [7:0]  DFLT_ACK_LIM = 8'd250;

    localparam int          HOLD_LEN      = 80;
    localparam int          SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_in                  i_in        = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_out                 o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    i2c_byte_master_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sequencer model: timing registers and state as the block holds them
    // ------------------------------------------------------------------------
    logic [15:0] tm_half    = DFLT_HALF;
    logic [15:0] tm_start   = DFLT_START;
    logic [7:0]  tm_ack_lim = DFLT_ACK_LIM;

    t_phase      m_phase    = PH_IDLE;
    logic [3:0]  m_bits     = '0;
    logic [7:0]  m_shift    = '0;
    logic [15:0] m_dly      = '0;
    logic [7:0]  m_polls    = '0;
    logic        m_scl      = 1'b1;
    logic        m_sda      = 1'b1;
    logic        m_nak      = 1'b0;
    logic        m_ack_send = 1'b0;
    logic [7:0]  m_rx_byte  = '0;

    // Line states still owed by the block, oldest first
    t_out        drive_due[$];
    t_out        drive_want;

    int          ticks_sent   = 0;
    int          mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;
    int          src_gap_pct  = 0;
    int          sink_pct     = 0;
    int unsigned hold_ticket  = 0;
    int unsigned hold_taken   = 0;
    int          hold_left    = 0;

    // Enter a timed segment; a zero count still lasts one tick
    function automatic void arm(input t_phase nxt, input logic [15:0] n);
        m_phase = nxt;
        m_dly   = (n == '0) ? 16'd1 : n;
    endfunction

    // Advance the model by one accepted tick and return the line state it owes
    function automatic t_out next_line_state(input t_in it);
        logic fin;
        t_out r;
        fin = 1'b0;
        if (m_phase == PH_IDLE) begin
            case (it.cmd)
                CMD_START: arm(PH_ST_A, tm_start);
                CMD_STOP: begin
                    m_scl = 1'b0;
                    m_sda = 1'b0;
                    arm(PH_SP_A, tm_half);
                end
                CMD_WRITE: begin
                    m_scl   = 1'b0;
                    m_shift = it.write_data;
                    m_bits  = '0;
                    arm(PH_WB_LO, tm_half);
                end
                CMD_WACK: begin
                    m_sda = 1'b1;
                    arm(PH_WA_A, tm_half);
                end
                CMD_READ: begin
                    m_scl      = 1'b0;
                    m_sda      = 1'b1;
                    m_shift    = '0;
                    m_bits     = '0;
                    m_ack_send = it.send_ack;
                    arm(PH_RB_LO, tm_half);
                end
                default: ;
            endcase
        end else if (m_phase == PH_WA_POLL) begin
            if (!it.sda_in) begin
                m_nak = 1'b0;
                m_scl = 1'b0;
                fin   = 1'b1;
            end else if (m_polls >= tm_ack_lim) begin
                // timeout leaves SCL released
                m_nak = 1'b1;
                fin   = 1'b1;
            end else begin
                m_polls = m_polls + 8'd1;
            end
        end else begin
            if (m_phase == PH_WB_LO) begin
                m_sda = m_shift[7];
            end else if (m_phase == PH_RA_LO) begin
                m_sda = !m_ack_send;
            end
            if (m_dly != '0) m_dly = m_dly - 16'd1;
            if (m_dly == '0) begin
                case (m_phase)
                    PH_ST_A: begin
                        m_sda = 1'b1;
                        m_scl = 1'b1;
                        arm(PH_ST_B, tm_start);
                    end
                    PH_ST_B: begin
                        m_sda = 1'b0;
                        arm(PH_ST_C1, tm_start);
                    end
                    PH_ST_C1: arm(PH_ST_C2, tm_start);
                    PH_ST_C2: begin
                        m_scl = 1'b0;
                        fin   = 1'b1;
                    end
                    PH_SP_A: begin
                        m_scl = 1'b1;
                        m_sda = 1'b1;
                        arm(PH_SP_B, tm_half);
                    end
                    PH_SP_B: fin = 1'b1;
                    PH_WA_A: begin
                        m_scl = 1'b1;
                        arm(PH_WA_B, tm_half);
                    end
                    PH_WA_B: begin
                        m_phase = PH_WA_POLL;
                        m_polls = '0;
                    end
                    PH_WB_LO: begin
                        m_scl = 1'b1;
                        arm(PH_WB_HI, tm_half);
                    end
                    PH_WB_HI: begin
                        m_shift = {m_shift[6:0], 1'b0};
                        m_bits  = m_bits + 4'd1;
                        m_scl   = 1'b0;
                        if (m_bits >= 4'd8) begin
                            fin = 1'b1;
                        end else begin
                            arm(PH_WB_LO, tm_half);
                        end
                    end
                    PH_RB_LO: begin
                        m_scl = 1'b1;
                        arm(PH_RB_HI, tm_half);
                    end
                    PH_RB_HI: begin
                        // sample SDA on the last high tick of the bit
                        m_shift = {m_shift[6:0], it.sda_in};
                        m_bits  = m_bits + 4'd1;
                        m_scl   = 1'b0;
                        if (m_bits >= 4'd8) begin
                            arm(PH_RA_LO, tm_half);
                        end else begin
                            arm(PH_RB_LO, tm_half);
                        end
                    end
                    PH_RA_LO: begin
                        m_scl = 1'b1;
                        arm(PH_RA_HI, tm_half);
                    end
                    PH_RA_HI: begin
                        m_scl     = 1'b0;
                        m_rx_byte = m_shift;
                        fin       = 1'b1;
                    end
                    default: fin = 1'b1;
                endcase
            end
        end
        if (fin) m_phase = PH_IDLE;
        r.scl_drive = m_scl;
        r.sda_drive = m_sda;
        r.busy_res  = (m_phase != PH_IDLE);
        r.done_res  = fin;
        r.read_byte = m_rx_byte;
        r.ack_error = m_nak;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare every accepted result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (drive_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("cycle %0d: result with nothing expected: %p", cycle_cnt, o_out);
                end
            end else begin
                drive_want = drive_due.pop_front();
                if (o_out.scl_drive !== drive_want.scl_drive
                        || o_out.sda_drive !== drive_want.sda_drive
                        || o_out.busy_res  !== drive_want.busy_res
                        || o_out.done_res  !== drive_want.done_res
                        || o_out.read_byte !== drive_want.read_byte
                        || o_out.ack_error !== drive_want.ack_error) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("cycle %0d: mismatch", cycle_cnt);
                        $display("  expected scl=%b sda=%b busy=%b done=%b rd=%h err=%b",
                                 drive_want.scl_drive, drive_want.sda_drive,
                                 drive_want.busy_res, drive_want.done_res,
                                 drive_want.read_byte, drive_want.ack_error);
                        $display("  actual   scl=%b sda=%b busy=%b done=%b rd=%h err=%b",
                                 o_out.scl_drive, o_out.sda_drive, o_out.busy_res,
                                 o_out.done_res, o_out.read_byte, o_out.ack_error);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result-side stall: random per cycle, or a long hold-off on request.
    // Each new ticket starts a hold that keeps i_stall high until its counter runs out.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_ticket != hold_taken) begin
            hold_taken <= hold_ticket;
            hold_left  <= HOLD_LEN - 1;
            i_stall    <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < sink_pct);
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout: %0d results still outstanding", drive_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one tick, hold it through stalls, and predict its result once taken.
    // Valid stays high on return so the next tick can follow without a gap.
    task automatic push_tick(input t_in item);
        while ($urandom_range(99) < src_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        drive_due.push_back(next_line_state(item));
        ticks_sent++;
    endtask

    // Issue a command at idle, then feed ticks until the sequencer is idle again.
    // While busy, every field is random: commands then must be ignored. During
    // the acknowledge poll SDA reads high for ack_hold polls, then low.
    task automatic run_cmd(input t_cmd code, input logic [7:0] wd, input logic sack,
                           input int ack_hold);
        t_in item;
        item.cmd        = code;
        item.write_data = wd;
        item.send_ack   = sack;
        item.sda_in     = 1'($urandom);
        push_tick(item);
        while (m_phase != PH_IDLE) begin
            item.cmd        = t_cmd'(3'($urandom_range(7)));
            item.write_data = 8'($urandom);
            item.send_ack   = 1'($urandom);
            if (m_phase == PH_WA_POLL) begin
                item.sda_in = (int'(m_polls) < ack_hold);
            end else begin
                item.sda_in = 1'($urandom);
            end
            push_tick(item);
        end
    endtask

    // Stop offering and wait until every predicted result has been taken
    task automatic drain_results();
        i_valid <= 1'b0;
        while (drive_due.size() != 0) @(posedge i_clk);
    endtask

    // One register write transaction; valid stays high for a following write
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_HALF_PERIOD: tm_half    = val;
            CFG_START_DELAY: tm_start   = val;
            CFG_ACK_LIMIT:   tm_ack_lim = val[7:0];
            default: ;
        endcase
    endtask

    // Retime the block while idle: all registers plus a write to the spare
    // index, which must change nothing. Upper ack limit bits are junk.
    task automatic program_timing(input logic [15:0] half, input logic [15:0] sdly,
                                  input logic [7:0] alim);
        drain_results();
        cfg_put(CFG_HALF_PERIOD, half);
        cfg_put(CFG_START_DELAY, sdly);
        cfg_put(CFG_ACK_LIMIT, {8'($urandom), alim});
        cfg_put(CFG_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int src, input int sink);
        src_gap_pct = src;
        sink_pct   <= sink;
    endtask

    // Mostly short delays, now and then zero or a longer one
    function automatic logic [15:0] pick_delay();
        if ($urandom_range(9) == 0) return 16'($urandom_range(12));
        return 16'($urandom_range(1, 2));
    endfunction

    // Acknowledge on some poll within the limit, or hold SDA high past it
    function automatic int pick_ack_hold();
        if ($urandom_range(99) < 70) return $urandom_range(int'(tm_ack_lim));
        return int'(tm_ack_lim) + 1 + $urandom_range(3);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Idle ticks with no command or an unknown code must leave the block idle
    task automatic test_ignored_codes();
        run_cmd(CMD_NONE, 8'h00, 1'b0, 0);
        run_cmd(t_cmd'(CMD_RSVD6), 8'hFF, 1'b1, 0);
        run_cmd(t_cmd'(CMD_RSVD7), 8'($urandom), 1'($urandom), 0);
    endtask

    // Timing straight out of reset: 100-tick steps and 250 tolerated polls
    task automatic test_reset_defaults();
        run_cmd(CMD_START, 8'($urandom), 1'($urandom), 0);
        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), int'(DFLT_ACK_LIM) + 1);
    endtask

    // Every command at the fastest timing, data extremes, ack limit boundary
    task automatic test_each_command();
        program_timing(16'd1, 16'd1, 8'd2);
        run_cmd(CMD_START, 8'($urandom), 1'($urandom), 0);
        run_cmd(CMD_WRITE, 8'h00, 1'b0, 0);
        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), 0);
        run_cmd(CMD_WRITE, 8'hFF, 1'b1, 0);
        // ack on the last poll the limit tolerates
        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), 2);
        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 0);
        // one high poll too many: timeout
        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), 3);
        run_cmd(CMD_READ, 8'($urandom), 1'b1, 0);
        run_cmd(CMD_READ, 8'($urandom), 1'b0, 0);
        run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 0);
    endtask

    // Zero delays act as one tick; a zero ack limit fails on the first high poll
    task automatic test_zero_settings();
        program_timing(16'd0, 16'd0, 8'd0);
        run_cmd(CMD_START, 8'($urandom), 1'($urandom), 0);
        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 0);
        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), 1);
        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), 0);
        run_cmd(CMD_READ, 8'($urandom), 1'($urandom), 0);
        run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 0);
    endtask

    // Random bus transfers with random content, plus stray and broken commands
    task automatic test_random_traffic(input int n_ticks);
        int stop_at;
        int retune_at;
        int n_ops;
        stop_at   = ticks_sent + n_ticks;
        retune_at = ticks_sent;
        while (ticks_sent < stop_at) begin
            if (ticks_sent >= retune_at) begin
                program_timing(pick_delay(), pick_delay(), 8'($urandom_range(6)));
                retune_at = ticks_sent + 200;
            end
            if ($urandom_range(99) < 80) begin
                // start, address byte with ack, a few data bytes, stop
                run_cmd(CMD_START, 8'($urandom), 1'($urandom), 0);
                run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 0);
                run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), pick_ack_hold());
                n_ops = $urandom_range(1, 3);
                repeat (n_ops) begin
                    if ($urandom_range(1) == 0) begin
                        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 0);
                        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), pick_ack_hold());
                    end else begin
                        run_cmd(CMD_READ, 8'($urandom), 1'($urandom), 0);
                    end
                end
                // now and then drop the stop and leave the bus hanging
                if ($urandom_range(9) != 0) begin
                    run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 0);
                end
            end else begin
                run_cmd(t_cmd'(3'($urandom_range(7))), 8'($urandom), 1'($urandom),
                        pick_ack_hold());
            end
        end
    endtask

    // Hold off the result side long enough that the block stalls its input,
    // then pause the sender until every result is back
    task automatic test_backpressure();
        program_timing(16'd2, 16'd1, 8'd4);
        hold_ticket <= hold_ticket + 1;
        run_cmd(CMD_START, 8'($urandom), 1'($urandom), 0);
        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 0);
        drain_results();
        run_cmd(CMD_READ, 8'($urandom), 1'($urandom), 0);
        run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 0);
    endtask

    // Highest ack limit: the wait fails only on the high poll after the
    // last one the limit tolerates
    task automatic test_slow_extremes();
        program_timing(16'd1, 16'd1, 8'd255);
        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), 256);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender gaps light, sink stalls heavy
        set_idling(28, 50);
        test_ignored_codes();
        test_reset_defaults();
        test_each_command();
        test_zero_settings();
        test_random_traffic(110);
        test_backpressure();

        // swap: sender gaps heavy, sink stalls light
        set_idling(50, 28);
        test_random_traffic(110);
        test_backpressure();

        // full rate on both sides
        set_idling(0, 0);
        test_random_traffic(110);
        test_slow_extremes();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/i2cbm_pkg.sv
rtl/i2c_byte_master_unit.sv
tb/i2c_byte_master_unit_test.sv
